// File: hw/rtl/assert_macros.svh
// Assertion macros used by int8_scaled_dot_product to check its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SDP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("sdp check failed");
`define SDP_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("sdp check failed");
`else
`define SDP_ASSERT(lbl, prop)
`define SDP_NEVER(lbl, cond)
`endif
`endif

// File: hw/rtl/sdp_pkg.sv
// Types and constants shared by the scaled dot product modules.
package sdp_pkg;

  localparam int unsigned BytesPerWord = 4;
  localparam logic [31:0] F32Nan = 32'h7FC0_0000;
  localparam logic [7:0] ExpMax = 8'hFF;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_NORM,
    FS_DENORM,
    FS_ROUND,
    FS_MUL,
    FS_DONE
  } fs_state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] sum;
    logic [31:0] row;
    logic [31:0] col;
  } fs_req_t;

  function automatic logic [15:0] to_bf16(input logic [31:0] u);
    logic [31:0] r;
    begin
      r = u + 32'h0000_7FFF + {31'b0, u[16]};
      if (u[30:23] == ExpMax && u[22:0] != 23'b0) begin
        to_bf16 = F32Nan[31:16];
      end else begin
        to_bf16 = r[31:16];
      end
    end
  endfunction

endpackage

// File: hw/rtl/int8_scaled_dot_product.sv
// Top level: int8 lanes, accumulator merge and the float scaling unit.
//
//   beat     direction  handshake              payload
//   input    in         in_valid / in_ready    act_bytes wgt_bytes end_of_row row_scale col_scale
//   result   out        out_valid / out_ready  result_bf16 dot_sum
//
// A beat without end_of_row is taken by the lanes and the adder, one per cycle while the
// float unit is idle. An end_of_row beat starts the float unit, which normalizes eight or
// one bits a cycle and runs its float32 multiplier twice; input stays blocked until the
// result beat is taken. Reset clears the accumulator and the float unit's control state.
// A stalled result holds, and no input is taken meanwhile.
`include "assert_macros.svh"
module int8_scaled_dot_product #(
  parameter int LANES = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [31:0]       act_bytes,
  input  logic [31:0]       wgt_bytes,
  input  logic              end_of_row,
  input  logic [31:0]       row_scale,
  input  logic [31:0]       col_scale,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       result_bf16,
  output logic signed [31:0] dot_sum
);

  localparam int Active = (LANES < sdp_pkg::BytesPerWord) ? LANES : sdp_pkg::BytesPerWord;

  logic signed [15:0] prod [Active];
  logic [31:0]        accum;
  logic [31:0]        lane_sum;
  logic [31:0]        accum_next;
  logic               accept;
  logic               busy;
  sdp_pkg::fs_req_t   req;

  for (genvar i = 0; i < Active; i++) begin : g_lane
    sdp_lane u_lane (
      .act_byte(act_bytes[8*i +: 8]),
      .wgt_byte(wgt_bytes[8*i +: 8]),
      .prod    (prod[i])
    );
  end

  always_comb begin
    lane_sum = 32'b0;
    for (int i = 0; i < Active; i++) begin
      lane_sum = lane_sum + {{16{prod[i][15]}}, prod[i]};
    end
    accum_next = accum + lane_sum;
  end

  assign in_ready = !busy;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      accum <= 32'b0;
    end else if (accept) begin
      accum <= end_of_row ? 32'b0 : accum_next;
    end
  end

  always_comb begin
    req.start = accept && end_of_row;
    req.sum = accum_next;
    req.row = row_scale;
    req.col = col_scale;
  end

  sdp_fscale u_fscale (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .result_bf16(result_bf16),
    .dot_sum    (dot_sum)
  );

  `SDP_NEVER(a_no_overlap, in_ready && out_valid)
  `SDP_ASSERT(a_last_blocks, (accept && end_of_row) |=> !in_ready)
  `SDP_ASSERT(a_free_after_out, (out_valid && out_ready) |=> in_ready && !out_valid)

endmodule

// File: hw/rtl/sdp_lane.sv
// One lane: signed product of an activation byte and a weight byte.
module sdp_lane (
  input  logic [7:0]         act_byte,
  input  logic [7:0]         wgt_byte,
  output logic signed [15:0] prod
);

  assign prod = $signed(act_byte) * $signed(wgt_byte);

endmodule

// File: hw/rtl/sdp_fscale.sv
// Float path: int32 to float32, two float32 multiplies, bfloat16 result.
module sdp_fscale (
  input  logic              clk,
  input  logic              rst,
  input  sdp_pkg::fs_req_t  req,
  output logic              busy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       result_bf16,
  output logic signed [31:0] dot_sum
);

  sdp_pkg::fs_state_t state, state_next;

  logic [1:0]         pass;
  logic               sgn;
  logic               zero;
  logic [47:0]        m;
  logic signed [11:0] e;
  logic signed [11:0] be_eff;
  logic               sticky;
  logic [31:0]        cur;
  logic [31:0]        row;
  logic [31:0]        col;
  logic [31:0]        sum_q;

  logic signed [11:0] be;
  logic [5:0]         sh;
  logic [95:0]        wide;
  logic [24:0]        q_r;
  logic signed [11:0] bexp;
  logic [31:0]        rnd_bits;

  logic [31:0] opb;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        nan_a, nan_b, inf_a, inf_b, zr_a, zr_b, sp, mul_special;
  logic [31:0] sp_bits;

  always_comb begin
    be = e + 12'sd174;
    sh = 6'd0;
    if (be <= 12'sd0) begin
      if (be < -12'sd48) begin
        sh = 6'd49;
      end else begin
        sh = 6'(12'sd1 - be);
      end
    end
    wide = {m, 48'b0} >> sh;
  end

  always_comb begin
    q_r = {1'b0, m[47:24]} + {24'b0, m[23] & ((|m[22:0]) | sticky | m[24])};
    bexp = be_eff;
    if (q_r[24]) begin
      q_r = q_r >> 1;
      bexp = be_eff + 12'sd1;
    end
    if (zero) begin
      rnd_bits = {sgn, 31'b0};
    end else if (bexp >= 12'sd255) begin
      rnd_bits = {sgn, sdp_pkg::ExpMax, 23'b0};
    end else begin
      rnd_bits = {sgn, q_r[23] ? bexp[7:0] : 8'h00, q_r[22:0]};
    end
  end

  always_comb begin
    opb = (pass == 2'd0) ? row : col;
    ea = cur[30:23];
    eb = opb[30:23];
    ma = {ea != 8'h00, cur[22:0]};
    mb = {eb != 8'h00, opb[22:0]};
    nan_a = ea == sdp_pkg::ExpMax && cur[22:0] != 23'b0;
    nan_b = eb == sdp_pkg::ExpMax && opb[22:0] != 23'b0;
    inf_a = ea == sdp_pkg::ExpMax && cur[22:0] == 23'b0;
    inf_b = eb == sdp_pkg::ExpMax && opb[22:0] == 23'b0;
    zr_a = cur[30:0] == 31'b0;
    zr_b = opb[30:0] == 31'b0;
    sp = cur[31] ^ opb[31];
    mul_special = nan_a | nan_b | inf_a | inf_b | zr_a | zr_b;
    if (nan_a || nan_b || (inf_a && zr_b) || (zr_a && inf_b)) begin
      sp_bits = sdp_pkg::F32Nan;
    end else if (inf_a || inf_b) begin
      sp_bits = {sp, sdp_pkg::ExpMax, 23'b0};
    end else begin
      sp_bits = {sp, 31'b0};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sdp_pkg::FS_IDLE: begin
        if (req.start) state_next = sdp_pkg::FS_NORM;
      end
      sdp_pkg::FS_NORM: begin
        if (m == 48'b0) begin
          state_next = sdp_pkg::FS_ROUND;
        end else if (m[47]) begin
          state_next = sdp_pkg::FS_DENORM;
        end
      end
      sdp_pkg::FS_DENORM: state_next = sdp_pkg::FS_ROUND;
      sdp_pkg::FS_ROUND: begin
        state_next = (pass == 2'd2) ? sdp_pkg::FS_DONE : sdp_pkg::FS_MUL;
      end
      sdp_pkg::FS_MUL: begin
        if (!mul_special) begin
          state_next = sdp_pkg::FS_NORM;
        end else if (pass == 2'd1) begin
          state_next = sdp_pkg::FS_DONE;
        end
      end
      sdp_pkg::FS_DONE: begin
        if (out_ready) state_next = sdp_pkg::FS_IDLE;
      end
      default: state_next = sdp_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdp_pkg::FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sdp_pkg::FS_IDLE: begin
        if (req.start) begin
          pass <= 2'd0;
          row <= req.row;
          col <= req.col;
          sum_q <= req.sum;
          sgn <= req.sum[31];
          zero <= req.sum == 32'b0;
          m <= {16'b0, req.sum[31] ? (~req.sum + 32'd1) : req.sum};
          e <= 12'sd0;
        end
      end
      sdp_pkg::FS_NORM: begin
        if (m != 48'b0 && !m[47]) begin
          if (m[47:40] == 8'b0) begin
            m <= m << 8;
            e <= e - 12'sd8;
          end else begin
            m <= m << 1;
            e <= e - 12'sd1;
          end
        end
      end
      sdp_pkg::FS_DENORM: begin
        m <= wide[95:48];
        sticky <= |wide[47:0];
        be_eff <= (be <= 12'sd0) ? 12'sd1 : be;
      end
      sdp_pkg::FS_ROUND: begin
        cur <= rnd_bits;
      end
      sdp_pkg::FS_MUL: begin
        pass <= pass + 2'd1;
        if (mul_special) begin
          cur <= sp_bits;
        end else begin
          m <= ma * mb;
          e <= $signed({4'b0, (ea == 8'h00) ? 8'h01 : ea})
             + $signed({4'b0, (eb == 8'h00) ? 8'h01 : eb}) - 12'sd300;
          sgn <= sp;
          zero <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy = state != sdp_pkg::FS_IDLE;
  assign out_valid = state == sdp_pkg::FS_DONE;
  assign result_bf16 = sdp_pkg::to_bf16(cur);
  assign dot_sum = sum_q;

endmodule
